@@ design/npn_canonical_form_search_assert.svh @@
// ---------------------------------------------------------------------------
// npn_canonical_form_search_assert.svh
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef NPN_CANONICAL_FORM_SEARCH_ASSERT_SVH
`define NPN_CANONICAL_FORM_SEARCH_ASSERT_SVH

// same-cycle implication, ignored during reset
`define NPNCF_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("npncf assertion failed");

// next-cycle implication, ignored during reset
`define NPNCF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("npncf assertion failed");

// what must hold in the cycle after reset
`define NPNCF_ASSERT_RESET(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("npncf reset assertion failed");

`endif

@@ design/npncf_pkg.sv @@
// ---------------------------------------------------------------------------
// npncf_pkg
// Field widths and elaboration helpers for the NPN canonical form search.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package npncf_pkg;

   localparam int TABLE_W  = 16;
   localparam int ORDER_W  = 8;
   localparam int IFLIP_W  = 4;
   localparam int OFLIP_W  = 1;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   function automatic int fact(input int n);
      int r;
      r = 1;
      for (int i = 1; i <= 4; i++) begin
         if (i <= n) r = r * i;
      end
      return r;
   endfunction

endpackage

@@ design/npncf_leaf.sv @@
// ---------------------------------------------------------------------------
// npncf_leaf
// One input negation and permutation of the table, with the output
// negation that clears the top row (the smallest of the output masks).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module npncf_leaf #(
   parameter int NUM_INPUTS  = 4,
   parameter int NUM_OUTPUTS = 1,
   parameter int NEG         = 0,
   parameter int PIDX        = 0
) (
   input  logic [(1 << NUM_INPUTS) * NUM_OUTPUTS - 1:0] f_i,
   output logic [(1 << NUM_INPUTS) * NUM_OUTPUTS - 1:0] tbl_o,
   output logic [npncf_pkg::ORDER_W-1:0]                order_o,
   output logic [npncf_pkg::IFLIP_W-1:0]                iflip_o,
   output logic [npncf_pkg::OFLIP_W-1:0]                oflip_o
);
   import npncf_pkg::*;

   localparam int ROWS = 1 << NUM_INPUTS;
   localparam int TW   = ROWS * NUM_OUTPUTS;

   // lexicographic permutation number k of n entries
   function automatic logic [ORDER_W-1:0] perm_at(input int k, input int n);
      int rem, fv, idx, cnt;
      logic [3:0] used;
      logic [ORDER_W-1:0] res;
      rem  = k;
      used = '0;
      res  = '0;
      for (int i = 0; i < 4; i++) begin
         if (i < n) begin
            fv  = fact(n - 1 - i);
            idx = 0;
            for (int j = 0; j < 3; j++) begin
               if (rem >= fv) begin
                  rem = rem - fv;
                  idx = idx + 1;
               end
            end
            cnt = 0;
            for (int c = 0; c < 4; c++) begin
               if (c < n && !used[c]) begin
                  if (cnt == idx) begin
                     res[2*i +: 2] = 2'(c);
                     used[c] = 1'b1;
                  end
                  cnt = cnt + 1;
               end
            end
         end
      end
      return res;
   endfunction

   localparam logic [ORDER_W-1:0] PERM = perm_at(PIDX, NUM_INPUTS);

   function automatic int zmap(input int x);
      int y, z;
      y = x ^ NEG;
      z = 0;
      for (int j = 0; j < NUM_INPUTS; j++) begin
         z = z | (((y >> PERM[2*j +: 2]) & 1) << j);
      end
      return z;
   endfunction

   function automatic logic [IFLIP_W-1:0] pneg_calc();
      logic [IFLIP_W-1:0] r;
      r = '0;
      for (int i = 0; i < NUM_INPUTS; i++) begin
         r[i] = 1'((NEG >> PERM[2*i +: 2]) & 1);
      end
      return r;
   endfunction

   localparam logic [IFLIP_W-1:0] PNEG = pneg_calc();

   logic [TW-1:0]          base;
   logic [NUM_OUTPUTS-1:0] om;

   for (genvar x = 0; x < ROWS; x++) begin : g_row
      localparam int Z = zmap(x);
      assign base[Z*NUM_OUTPUTS +: NUM_OUTPUTS] = f_i[x*NUM_OUTPUTS +: NUM_OUTPUTS];
   end

   assign om = base[TW-1 -: NUM_OUTPUTS];
   assign tbl_o   = base ^ {ROWS{om}};
   assign order_o = PERM;
   assign iflip_o = PNEG;
   assign oflip_o = om[0];

endmodule

@@ design/npn_canonical_form_search.sv @@
// ---------------------------------------------------------------------------
// npn_canonical_form_search
// Exhaustive NPN canonical form of a packed truth table, fully pipelined.
// ---------------------------------------------------------------------------
//  channel | dir | tdata                                   | handshake
//  req     | in  | [15:0] truth_table                      | tvalid/tready
//  rsp     | out | [15:0] canonical_table, [23:16] order,  | tvalid/tready
//          |     | [27:24] input_flip, [28] output_flip    |
//
// One request per cycle unless the response stalls. Tree depth is log2 of the
// leaf count padded to a power of two (at 4 inputs: 384 candidates in a 9-level tree).
// Every negation/permutation pair is built as wiring into leaf registers,
// then a registered min tree keeps the earliest smallest candidate.
// Reset clears the stage valid bits only. A stalled stage holds; bubbles
// collapse, so a waiting result never blocks upstream stages with room.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module npn_canonical_form_search #(
   parameter int NUM_INPUTS  = 4,
   parameter int NUM_OUTPUTS = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [npncf_pkg::REQ_DATA_W-1:0]  req_tdata,  // [15:0] truth_table
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [15:0] canonical_table, [23:16] input_order, [27:24] input_flip,
   // [28] output_flip, [31:29] zero
   output logic [npncf_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import npncf_pkg::*;

   localparam int ROWS  = 1 << NUM_INPUTS;
   localparam int TW    = ROWS * NUM_OUTPUTS;
   localparam int IW    = (TW < TABLE_W) ? TW : TABLE_W;
   localparam int NPERM = fact(NUM_INPUTS);
   localparam int NPAIR = ROWS * NPERM;
   localparam int LVL   = $clog2(NPAIR);
   localparam int LP    = 1 << LVL;
   localparam int NODES = 2 * LP - 1;

   typedef struct packed {
      logic [TW-1:0]      tbl;
      logic [ORDER_W-1:0] order;
      logic [IFLIP_W-1:0] iflip;
      logic [OFLIP_W-1:0] oflip;
   } node_type;

   logic [TW-1:0] in_ff;
   logic          v_ff [0:LVL+1];
   logic          adv  [0:LVL+1];
   node_type      leaf_in [0:LP-1];
   node_type      tree_ff [0:NODES-1];

   always_comb begin
      adv[LVL+1] = !v_ff[LVL+1] || rsp_tready;
      for (int k = LVL; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   assign req_tready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LVL + 1; k++) v_ff[k] <= 1'b0;
      end else begin
         if (adv[0]) v_ff[0] <= req_tvalid;
         for (int k = 1; k <= LVL + 1; k++) begin
            if (adv[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) in_ff <= TW'(req_tdata[IW-1:0]);
   end

   for (genvar p = 0; p < LP; p++) begin : g_leaf
      if (p < NPAIR) begin : g_real
         npncf_leaf #(
            .NUM_INPUTS (NUM_INPUTS),
            .NUM_OUTPUTS(NUM_OUTPUTS),
            .NEG        (p / NPERM),
            .PIDX       (p % NPERM)
         ) u_leaf (
            .f_i    (in_ff),
            .tbl_o  (leaf_in[p].tbl),
            .order_o(leaf_in[p].order),
            .iflip_o(leaf_in[p].iflip),
            .oflip_o(leaf_in[p].oflip)
         );
      end else begin : g_pad
         // never wins: ties keep the lower index
         assign leaf_in[p] = '{tbl: '1, order: '0, iflip: '0, oflip: '0};
      end
      always_ff @(posedge clock) begin
         if (adv[1]) tree_ff[LP-1+p] <= leaf_in[p];
      end
   end

   for (genvar i = 0; i < LP - 1; i++) begin : g_node
      localparam int ST = LVL + 2 - $clog2(i + 2);
      node_type lo, hi;
      assign lo = tree_ff[2*i+1];
      assign hi = tree_ff[2*i+2];
      always_ff @(posedge clock) begin
         if (adv[ST]) tree_ff[i] <= (hi.tbl < lo.tbl) ? hi : lo;
      end
   end

   assign rsp_tvalid = v_ff[LVL+1];
   assign rsp_tdata  = {3'b000, tree_ff[0].oflip, tree_ff[0].iflip, tree_ff[0].order,
                        TABLE_W'(tree_ff[0].tbl[IW-1:0])};

endmodule

@@ design/npncf_checker.sv @@
// ---------------------------------------------------------------------------
// npncf_checker
// Port-level checks on the NPN canonical form search.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "npn_canonical_form_search_assert.svh"

module npncf_checker #(
   parameter int NUM_INPUTS  = 4,
   parameter int NUM_OUTPUTS = 1
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [npncf_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [npncf_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import npncf_pkg::*;

   localparam int TW = (1 << NUM_INPUTS) * NUM_OUTPUTS;
   localparam int TB = (TW <= TABLE_W) ? TW - 1 : 0;
   localparam bit WIDE = TW > TABLE_W;

   logic unused_req;
   assign unused_req = req_tvalid & (|req_tdata);

   `NPNCF_ASSERT_RESET(a_reset_empty, !rsp_tvalid)
   `NPNCF_ASSERT_NOW(a_ready_flows, rsp_tready, req_tready)
   `NPNCF_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `NPNCF_ASSERT_NOW(a_top_row_clear, rsp_tvalid, WIDE || !rsp_tdata[TB])
   `NPNCF_ASSERT_NOW(a_pad_zero, rsp_tvalid || unused_req, rsp_tdata[31:29] == 3'b000)

endmodule

bind npn_canonical_form_search npncf_checker #(
   .NUM_INPUTS (NUM_INPUTS),
   .NUM_OUTPUTS(NUM_OUTPUTS)
) u_npncf_checker (.*);
